// ----- hw/rtl/usv_pkg.sv -----
// ----------------------------------------------------------------------------
// usv_pkg
// shared types and constants of the utf-8 stream validator
// ----------------------------------------------------------------------------
package usv_pkg;

  localparam int unsigned CpW     = 21;   // code point width
  localparam int unsigned QDepth  = 2;    // classified item queue depth

  localparam logic [7:0] LeadTwoLo   = 8'hc2;
  localparam logic [7:0] LeadTwoHi   = 8'hdf;
  localparam logic [7:0] LeadThreeLo = 8'he0;
  localparam logic [7:0] LeadFourLo  = 8'hf0;
  localparam logic [7:0] LeadFourHi  = 8'hf4;
  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] ContMask    = 8'hc0;
  localparam logic [7:0] ContTag     = 8'h80;
  localparam logic [7:0] ContBits    = 8'h3f;

  localparam logic [CpW-1:0] MinTwo     = 21'h00080;
  localparam logic [CpW-1:0] MinThree   = 21'h00800;
  localparam logic [CpW-1:0] MinFour    = 21'h10000;
  localparam logic [CpW-1:0] MaxCp      = 21'h10ffff;
  localparam logic [CpW-1:0] SurrLo     = 21'h0d800;
  localparam logic [CpW-1:0] SurrHi     = 21'h0dfff;

  // class of a byte when it stands where a lead byte is expected
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_NUL,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } usv_lead_e;

  // one classified item as it travels from front to back
  typedef struct packed {
    usv_lead_e   lead;       // class as a lead byte
    logic [4:0]  lead_bits;  // payload bits of a lead byte
    logic        is_cont;    // byte has the form 10xxxxxx
    logic [5:0]  cont_bits;  // payload bits of a continuation byte
    logic        last;       // final byte of the string
    logic        empty;      // zero-length string, no byte
  } usv_item_t;

endpackage

// ----- hw/rtl/usv_front.sv -----
// ----------------------------------------------------------------------------
// usv_front
// classifies each incoming byte and pushes it into the item queue
// ----------------------------------------------------------------------------
module usv_front (
  input  logic              in_valid_i,
  input  logic [7:0]        byte_value_i,
  input  logic              end_of_string_i,
  input  logic              empty_marker_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output usv_pkg::usv_item_t item_o
);

  usv_pkg::usv_lead_e lead;
  logic [4:0]         lead_bits;

  always_comb begin
    lead_bits = 5'd0;
    if (byte_value_i < usv_pkg::AsciiLimit) begin
      lead = (byte_value_i == 8'd0) ? usv_pkg::LEAD_NUL : usv_pkg::LEAD_ASCII;
    end else if (byte_value_i >= usv_pkg::LeadTwoLo && byte_value_i <= usv_pkg::LeadTwoHi) begin
      lead      = usv_pkg::LEAD_TWO;
      lead_bits = byte_value_i[4:0];
    end else if (byte_value_i >= usv_pkg::LeadThreeLo && byte_value_i < usv_pkg::LeadFourLo) begin
      lead      = usv_pkg::LEAD_THREE;
      lead_bits = {1'b0, byte_value_i[3:0]};
    end else if (byte_value_i >= usv_pkg::LeadFourLo && byte_value_i <= usv_pkg::LeadFourHi) begin
      lead      = usv_pkg::LEAD_FOUR;
      lead_bits = {2'b00, byte_value_i[2:0]};
    end else begin
      lead = usv_pkg::LEAD_BAD;
    end
  end

  assign item_o.lead      = lead;
  assign item_o.lead_bits = lead_bits;
  assign item_o.is_cont   = (byte_value_i & usv_pkg::ContMask) == usv_pkg::ContTag;
  assign item_o.cont_bits = byte_value_i[5:0] & usv_pkg::ContBits[5:0];
  assign item_o.last      = end_of_string_i;
  assign item_o.empty     = empty_marker_i;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

// ----- hw/rtl/usv_queue.sv -----
// ----------------------------------------------------------------------------
// usv_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module usv_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  usv_pkg::usv_item_t push_item_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               not_empty_o,
  output usv_pkg::usv_item_t head_o
);

  localparam int unsigned PtrW = $clog2(usv_pkg::QDepth);
  localparam int unsigned CntW = $clog2(usv_pkg::QDepth + 1);

  usv_pkg::usv_item_t         mem_q [usv_pkg::QDepth];
  logic [PtrW-1:0]            wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]            count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(usv_pkg::QDepth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign full_o      = count_q == CntW'(usv_pkg::QDepth);
  assign not_empty_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hw/rtl/usv_back.sv -----
// ----------------------------------------------------------------------------
// usv_back
// sequence state update and verdict register
// ----------------------------------------------------------------------------
module usv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               zero_ok_i,
  input  logic               q_not_empty_i,
  input  usv_pkg::usv_item_t item_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               string_valid_o
);

  localparam int unsigned CpW = usv_pkg::CpW;

  logic [1:0]     pend_q, pend_d;
  logic [CpW-1:0] cp_q, cp_d;
  logic [1:0]     seq_q, seq_d;
  logic           err_q, err_d;
  logic           out_valid_q, out_valid_d;
  logic           verdict_q, verdict_d;

  logic           gives_result;
  logic           out_free;
  logic [CpW-1:0] cp_shift;
  logic [1:0]     pend_dec;
  logic [CpW-1:0] minimum;
  logic           verdict;

  assign gives_result = item_i.empty || item_i.last;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign pop_o        = q_not_empty_i && (!gives_result || out_free);

  assign cp_shift = {cp_q[CpW-7:0], item_i.cont_bits};
  assign pend_dec = pend_q - 2'd1;

  always_comb begin
    unique case (seq_q)
      2'd1:    minimum = usv_pkg::MinTwo;
      2'd2:    minimum = usv_pkg::MinThree;
      default: minimum = usv_pkg::MinFour;
    endcase
  end

  always_comb begin
    pend_d  = pend_q;
    cp_d    = cp_q;
    seq_d   = seq_q;
    err_d   = err_q;
    verdict = 1'b0;
    if (pop_o) begin
      if (!item_i.empty) begin
        if (pend_q == 2'd0) begin
          unique case (item_i.lead)
            usv_pkg::LEAD_ASCII: ;
            usv_pkg::LEAD_NUL: begin
              if (!zero_ok_i) err_d = 1'b1;
            end
            usv_pkg::LEAD_TWO: begin
              cp_d   = CpW'(item_i.lead_bits);
              pend_d = 2'd1;
              seq_d  = 2'd1;
            end
            usv_pkg::LEAD_THREE: begin
              cp_d   = CpW'(item_i.lead_bits);
              pend_d = 2'd2;
              seq_d  = 2'd2;
            end
            usv_pkg::LEAD_FOUR: begin
              cp_d   = CpW'(item_i.lead_bits);
              pend_d = 2'd3;
              seq_d  = 2'd3;
            end
            default: err_d = 1'b1;
          endcase
        end else if (!item_i.is_cont) begin
          // broken sequence: drop it and look at later bytes afresh
          err_d  = 1'b1;
          pend_d = 2'd0;
          cp_d   = '0;
          seq_d  = 2'd0;
        end else begin
          pend_d = pend_dec;
          cp_d   = cp_shift;
          if (pend_dec == 2'd0) begin
            if (cp_shift < minimum || cp_shift > usv_pkg::MaxCp ||
                (cp_shift >= usv_pkg::SurrLo && cp_shift <= usv_pkg::SurrHi)) begin
              err_d = 1'b1;
            end
            cp_d  = '0;
            seq_d = 2'd0;
          end
        end
      end
      if (gives_result) begin
        verdict = !err_d && (pend_d == 2'd0);
        pend_d  = 2'd0;
        cp_d    = '0;
        seq_d   = 2'd0;
        err_d   = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    if (pop_o && gives_result) begin
      out_valid_d = 1'b1;
      verdict_d   = verdict;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 2'd0;
      cp_q        <= '0;
      seq_q       <= 2'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      cp_q        <= cp_d;
      seq_q       <= seq_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign out_valid_o    = out_valid_q;
  assign string_valid_o = verdict_q;

endmodule

// ----- hw/rtl/utf8_stream_validator_core.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// strict utf-8 checker for a byte stream, one verdict per string
// ----------------------------------------------------------------------------
// Takes one byte per item and one item per clock cycle unless the item queue
// is full. Each string ends with an item carrying end_of_string_i, or with an
// empty_marker_i item (no byte); that item yields exactly one result,
// string_valid_o, via the queue and verdict register. Other items yield nothing.
// Rejected: lead bytes 0x80-0xc1 and 0xf5-0xff, continuation bytes not of the
// form 10xxxxxx, overlong forms, surrogates, code points above 0x10ffff,
// sequences cut short at the string end, and zero bytes unless the zero-byte
// permit is set through cfg_we_i / cfg_wdata_i (write it only while the block
// is idle).
// The rate is set by the sequence state update loop in the back end; a
// two-entry item queue lets input keep flowing while a verdict waits.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_value_i,
  input  logic       end_of_string_i,
  input  logic       empty_marker_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       string_valid_o
);

  // zero-byte permit register
  logic zero_ok_q, zero_ok_d;

  // front to queue
  logic               push;
  usv_pkg::usv_item_t push_item;
  logic               q_full;

  // queue to back
  logic               pop;
  logic               q_not_empty;
  usv_pkg::usv_item_t head_item;

  assign zero_ok_d = cfg_we_i ? cfg_wdata_i : zero_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_ok_q <= 1'b0;
    end else begin
      zero_ok_q <= zero_ok_d;
    end
  end

  // byte classification, stalls only on a full queue
  usv_front u_front (
    .in_valid_i      (in_valid_i),
    .byte_value_i    (byte_value_i),
    .end_of_string_i (end_of_string_i),
    .empty_marker_i  (empty_marker_i),
    .q_full_i        (q_full),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .item_o          (push_item)
  );

  // decouples the front from a stalled verdict
  usv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .head_o      (head_item)
  );

  // sequence tracking and verdict output register
  usv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .zero_ok_i      (zero_ok_q),
    .q_not_empty_i  (q_not_empty),
    .item_i         (head_item),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .string_valid_o (string_valid_o)
  );

endmodule

// ----- bench/tb_utf8_stream_validator_core.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_stream_validator_core
// self-checking bench for the strict utf-8 stream validator
// ----------------------------------------------------------------------------
// Sends byte strings, some well-formed and some broken on purpose, with random
// gaps on the input side and random stall on the output side. A scoreboard
// tracks the sequence state of every accepted item, works out the verdict each
// string should get and compares it with every string_valid_o that is taken.
// The zero-byte permit is rewritten between phases, once every verdict has
// arrived.
// ----------------------------------------------------------------------------
module tb_utf8_stream_validator_core;

  // ways a generated character can be built, good or broken
  typedef enum {
    CH_VALID,
    CH_SURROGATE,
    CH_OVERLONG,
    CH_TOO_BIG,
    CH_TRUNCATED,
    CH_BAD_CONT,
    CH_NOISE,
    CH_NUL
  } char_kind_e;

  localparam int unsigned StallLimit  = 1000;  // cycles without any handshake
  localparam int unsigned PhaseItems  = 370;   // random items per phase
  localparam int unsigned NumPhases   = 5;
  localparam int unsigned SettleCycles = 6;    // margin for the queue and the verdict register to empty

  // tracks the string state and the verdicts still owed by the block
  class utf8_verdict_board;
    bit          zero_ok;
    logic [1:0]  cont_due;
    logic [20:0] code_acc;
    logic [1:0]  seq_len;
    bit          err_seen;
    bit          verdict_q[$];
    int unsigned failures;

    function new();
      zero_ok  = 1'b0;
      failures = 0;
      clear_string();
    endfunction

    function void clear_string();
      cont_due = '0;
      code_acc = '0;
      seq_len  = '0;
      err_seen = 1'b0;
    endfunction

    // one accepted input item; queues a verdict when the string closes
    function void absorb_item(logic [7:0] b, logic last, logic empty);
      logic [20:0] floor_cp;
      if (!empty) begin
        if (cont_due == 2'd0) begin
          if (b < usv_pkg::AsciiLimit) begin
            if (b == 8'h00 && !zero_ok) err_seen = 1'b1;
          end else if (b >= usv_pkg::LeadTwoLo && b <= usv_pkg::LeadTwoHi) begin
            code_acc = {16'b0, b[4:0]};
            cont_due = 2'd1;
            seq_len  = 2'd1;
          end else if (b >= usv_pkg::LeadThreeLo && b < usv_pkg::LeadFourLo) begin
            code_acc = {17'b0, b[3:0]};
            cont_due = 2'd2;
            seq_len  = 2'd2;
          end else if (b >= usv_pkg::LeadFourLo && b <= usv_pkg::LeadFourHi) begin
            code_acc = {18'b0, b[2:0]};
            cont_due = 2'd3;
            seq_len  = 2'd3;
          end else begin
            err_seen = 1'b1;
          end
        end else if ((b & usv_pkg::ContMask) != usv_pkg::ContTag) begin
          // broken sequence is dropped, later bytes start afresh
          err_seen = 1'b1;
          cont_due = '0;
          code_acc = '0;
          seq_len  = '0;
        end else begin
          code_acc = {code_acc[14:0], b[5:0]};
          cont_due = cont_due - 2'd1;
          if (cont_due == 2'd0) begin
            floor_cp = (seq_len == 2'd1) ? usv_pkg::MinTwo :
                       (seq_len == 2'd2) ? usv_pkg::MinThree : usv_pkg::MinFour;
            if (code_acc < floor_cp || code_acc > usv_pkg::MaxCp ||
                (code_acc >= usv_pkg::SurrLo && code_acc <= usv_pkg::SurrHi)) begin
              err_seen = 1'b1;
            end
            code_acc = '0;
            seq_len  = '0;
          end
        end
        if (!last) return;
      end
      verdict_q.push_back(!err_seen && cont_due == 2'd0);
      clear_string();
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdict_q.size() == 0) begin
        $display("%0t: string_valid expected none, got %0b", $time, got);
        failures++;
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          $display("%0t: string_valid expected %0b, got %0b", $time, want, got);
          failures++;
        end
      end
    endfunction
  endclass

  // block ports, inputs driven to known values from time zero
  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic       cfg_wdata_i     = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [7:0] byte_value_i    = 8'h00;
  logic       end_of_string_i = 1'b0;
  logic       empty_marker_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic       string_valid_o;

  utf8_verdict_board board;

  logic [7:0]  text_q[$];       // bytes of the string being built
  int unsigned items_sent  = 0;
  int unsigned in_gap_pct  = 20;
  bit          quiet       = 1'b0;  // no idling on either side
  int unsigned idle_cycles = 0;
  int unsigned stall_len;
  bit          stall_on;

  utf8_stream_validator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .byte_value_i    (byte_value_i),
    .end_of_string_i (end_of_string_i),
    .empty_marker_i  (empty_marker_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .string_valid_o  (string_valid_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // monitor: handshakes are sampled on the edge, inputs change by nba only
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_verdict(string_valid_o);
      if (in_valid_i && !in_stall_o)
        board.absorb_item(byte_value_i, end_of_string_i, empty_marker_i);
    end
  end

  // watchdog: a long run of cycles with no handshake at all means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output stall in random bursts, free stretches run longer on average
  initial begin
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        stall_on  = ($urandom_range(0, 2) == 0);
        stall_len = $urandom_range(1, 16) * (stall_on ? 1 : $urandom_range(1, 4));
        repeat (stall_len) begin
          out_stall_i <= stall_on && !quiet;
          @(posedge clk_i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // present one item and hold it until taken, then maybe leave a gap
  task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
    in_valid_i      <= 1'b1;
    byte_value_i    <= b;
    end_of_string_i <= last;
    empty_marker_i  <= empty;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    // swap between gappy and back-to-back stretches now and then
    if ($urandom_range(0, 39) == 0) in_gap_pct = (in_gap_pct == 0) ? 25 : 0;
  endtask

  // send text_q as one string, closed by end flag or by an empty marker
  task automatic send_text(input bit by_marker);
    for (int i = 0; i < text_q.size(); i++)
      send_item(text_q[i], !by_marker && i == text_q.size() - 1, 1'b0);
    // marker fields other than the flag carry junk, the block ignores them
    if (by_marker || text_q.size() == 0)
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // register write, only ever issued while nothing is in flight
  task automatic write_zero_ok(input bit value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.zero_ok = value;
  endtask

  // drain every verdict and let the pipeline empty out
  task automatic settle();
    in_valid_i <= 1'b0;
    // one edge so the monitor has noted the last accepted item
    @(posedge clk_i);
    while (board.verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // string generation
  // ---------------------------------------------------------------------------

  // random value in a range, leaning on both ends
  function automatic logic [20:0] pick(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 21'(lo);
    if (r == 1) return 21'(hi);
    return 21'($urandom_range(lo, hi));
  endfunction

  // legal scalar value for an n-byte encoding
  function automatic logic [20:0] legal_cp(input int n);
    case (n)
      1:       return pick(32'h01, 32'h7f);
      2:       return pick(32'h80, 32'h7ff);
      3:       return $urandom_range(0, 1) ? pick(32'h800, 32'hd7ff) :
                                             pick(32'he000, 32'hffff);
      default: return pick(32'h10000, 32'h10ffff);
    endcase
  endfunction

  // encode cp in exactly n bytes, whatever its size
  function automatic void append_utf8(input logic [20:0] cp, input int n);
    case (n)
      1: text_q.push_back({1'b0, cp[6:0]});
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void add_char(input char_kind_e kind);
    int         n;
    logic [7:0] b;
    case (kind)
      CH_VALID: begin
        n = $urandom_range(1, 4);
        append_utf8(legal_cp(n), n);
      end
      CH_SURROGATE: append_utf8(pick(32'hd800, 32'hdfff), 3);
      CH_OVERLONG: begin
        // short value in a longer form, c0/c1 leads come out of the 2-byte case
        n = $urandom_range(2, 4);
        append_utf8(pick(0, (n == 2) ? 32'h7f : (n == 3) ? 32'h7ff : 32'hffff), n);
      end
      CH_TOO_BIG: append_utf8(pick(32'h110000, 32'h1fffff), 4);
      CH_TRUNCATED: begin
        n = $urandom_range(2, 4);
        append_utf8(legal_cp(n), n);
        repeat ($urandom_range(1, n - 1)) void'(text_q.pop_back());
      end
      CH_BAD_CONT: begin
        n = $urandom_range(2, 4);
        append_utf8(legal_cp(n), n);
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        text_q[text_q.size() - $urandom_range(1, n - 1)] = b;
      end
      CH_NOISE: text_q.push_back(8'($urandom_range(0, 255)));
      default: text_q.push_back(8'h00);
    endcase
  endfunction

  // about half the strings are clean, the rest mix in every kind of fault
  task automatic random_string();
    int         chars;
    bit         clean;
    int         r;
    char_kind_e kind;
    text_q.delete();
    chars = $urandom_range(0, 6);
    clean = ($urandom_range(0, 99) < 55);
    repeat (chars) begin
      r = $urandom_range(0, 99);
      if (clean)       kind = (r < 4) ? CH_NUL : CH_VALID;
      else if (r < 50) kind = CH_VALID;
      else if (r < 57) kind = CH_SURROGATE;
      else if (r < 64) kind = CH_OVERLONG;
      else if (r < 70) kind = CH_TOO_BIG;
      else if (r < 78) kind = CH_TRUNCATED;
      else if (r < 86) kind = CH_BAD_CONT;
      else if (r < 95) kind = CH_NOISE;
      else             kind = CH_NUL;
      add_char(kind);
    end
    send_text($urandom_range(0, 9) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_zero_ok(1'b0);

    // directed: boundaries and each kind of fault, zero bytes rejected
    send_item(8'h5a, 1'b1, 1'b1);                               // empty, nothing open
    text_q = '{8'h41};                         send_text(1'b0);
    text_q = '{8'h00};                         send_text(1'b0);  // nul refused
    text_q = '{8'h7f};                         send_text(1'b0);
    text_q = '{8'h80};                         send_text(1'b0);  // stray continuation
    text_q = '{8'hc2, 8'h80};                  send_text(1'b0);  // lowest two-byte
    text_q = '{8'he0, 8'h80, 8'h80};           send_text(1'b0);  // overlong
    text_q = '{8'hed, 8'ha0, 8'h80};           send_text(1'b0);  // surrogate
    text_q = '{8'hf4, 8'h90, 8'h80, 8'h80};    send_text(1'b0);  // above max
    text_q = '{8'hff};                         send_text(1'b0);
    text_q = '{8'he2, 8'h82};                  send_text(1'b0);  // cut short
    text_q = '{8'hc3, 8'h41};                  send_text(1'b0);  // bad continuation
    text_q = '{8'hc3};                         send_text(1'b1);  // marker mid-sequence

    // random phases with the zero-byte permit alternating, the last without idling
    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      write_zero_ok(phase % 2 == 0);
      quiet = (phase == NumPhases - 1);
      while (items_sent < 24 + (phase + 1) * PhaseItems) random_string();
    end

    settle();
    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/usv_pkg.sv
hw/rtl/usv_front.sv
hw/rtl/usv_queue.sv
hw/rtl/usv_back.sv
hw/rtl/utf8_stream_validator_core.sv
bench/tb_utf8_stream_validator_core.sv
